// ----- rtl/core/comdf_pkg.sv -----
// ----------------------------------------------------------------------------
// comdf_pkg
// Shared types and constants of the minimum-delay clock offset filter.
// ----------------------------------------------------------------------------
package comdf_pkg;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_DELAY = 2'd2;
    localparam logic [1:0] OP_POS   = 2'd3;

    localparam logic [13:0] TICKS_PER_MS = 14'd10000;
    localparam logic [61:0] POS_MAX      = 62'h3FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [49:0] delay;
        logic signed [49:0] offset;
    } sample_t;

    typedef struct packed {
        logic clr;
        logic take;
        logic first;
    } best_ctl_t;

endpackage

// ----- rtl/core/clock_offset_min_delay_filter.sv -----
// ----------------------------------------------------------------------------
// clock_offset_min_delay_filter
// NTP style clock filter: keeps the last WINDOW samples in a chain of cells
// and picks the one with the smallest round-trip delay.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   in      | input     | in_valid / in_ready | op, timestamps, query fields
//   out     | output    | out_valid/out_ready | ready_res, offset, ping, ...
//
// Add: shift in, rotation of the whole window past the comparator at the
// oldest cell, result load. Queries: difference, multiply, result load. Clear: result load.
// One transaction at a time; a new one is taken while the result register
// still waits. A full output register stalls the final step only.
// Reset empties the window and zeroes the chosen sample.
// ----------------------------------------------------------------------------
module clock_offset_min_delay_filter #(
    parameter int WINDOW = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [47:0] local_sent_ms,
    input  logic [47:0] server_received_ms,
    input  logic [47:0] server_sent_ms,
    input  logic [47:0] local_received_ms,
    input  logic [47:0] target_server_ms,
    input  logic [47:0] local_now_ms,
    input  logic [47:0] base_position_ticks,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        ready_res,
    output logic signed [49:0] offset_half_ms,
    output logic [48:0] ping_half_ms,
    output logic [48:0] delay_ms,
    output logic [61:0] position_estimate
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(WINDOW);
    localparam logic [CNT_W-1:0] STEP_END = CNT_W'(WINDOW - 1);
    localparam logic [CNT_W:0]   WIN_EXT  = (CNT_W + 1)'(WINDOW);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_QDIFF = 5'b00100,
        ST_QMUL  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [1:0]  op_reg, op_next;
    logic [47:0] tgt_reg, tgt_next;
    logic [47:0] now_reg, now_next;
    logic [47:0] base_reg, base_next;
    logic signed [49:0] rnd_reg, rnd_next;
    logic signed [51:0] diff_reg, diff_next;
    logic [63:0] prod_reg, prod_next;

    logic        out_valid_reg, out_valid_next;
    logic        ready_res_reg, ready_res_next;
    logic signed [49:0] offset_reg, offset_next;
    logic [48:0] ping_reg, ping_next;
    logic [48:0] delay_reg, delay_next;
    logic [61:0] pos_reg, pos_next;

    comdf_pkg::sample_t cell_d [WINDOW];
    comdf_pkg::sample_t cell_q [WINDOW];
    comdf_pkg::sample_t new_sample;
    comdf_pkg::sample_t best;
    comdf_pkg::best_ctl_t best_ctl;
    logic shift_en;
    logic accept;
    logic diff_pos;
    logic signed [50:0] s_ext;
    logic signed [50:0] s_inc;
    logic signed [50:0] s_half;
    logic signed [51:0] tgt_e, now_e, rnd_e;
    logic [63:0] pos_sum;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    assign new_sample.offset = $signed({2'b00, server_received_ms}) - $signed({2'b00, local_sent_ms})
                             + $signed({2'b00, server_sent_ms}) - $signed({2'b00, local_received_ms});
    assign new_sample.delay  = $signed({2'b00, local_received_ms}) - $signed({2'b00, local_sent_ms})
                             - $signed({2'b00, server_sent_ms}) + $signed({2'b00, server_received_ms});

    assign shift_en = (accept && (op == comdf_pkg::OP_ADD)) || (state_reg == ST_SCAN);

    assign cell_d[0] = (state_reg == ST_SCAN) ? cell_q[WINDOW-1] : new_sample;

    genvar gi;
    generate
        for (gi = 1; gi < WINDOW; gi++)
        begin : g_link
            assign cell_d[gi] = cell_q[gi-1];
        end
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            comdf_cell u_cell (
                .clk (clk),
                .en  (shift_en),
                .d   (cell_d[gi]),
                .q   (cell_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        best_ctl.clr   = accept && (op == comdf_pkg::OP_CLEAR);
        best_ctl.take  = (state_reg == ST_SCAN)
                         && (({1'b0, step_reg} + {1'b0, count_reg}) >= WIN_EXT);
        best_ctl.first = (({1'b0, step_reg} + {1'b0, count_reg}) == WIN_EXT);
    end

    comdf_best u_best (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (best_ctl),
        .cand  (cell_q[WINDOW-1]),
        .best  (best)
    );

    // offset in ms, rounded half away from zero
    assign s_ext  = {best.offset[49], best.offset};
    assign s_inc  = s_ext + 51'sd1;
    assign s_half = s_ext[50] ? (s_ext >>> 1) : (s_inc >>> 1);

    assign tgt_e = $signed({4'b0000, tgt_reg});
    assign now_e = $signed({4'b0000, now_reg});
    assign rnd_e = {{2{rnd_reg[49]}}, rnd_reg};
    assign diff_pos = !diff_reg[51] && (diff_reg != '0);
    assign pos_sum  = prod_reg + {16'h0000, base_reg};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        op_next        = op_reg;
        tgt_next       = tgt_reg;
        now_next       = now_reg;
        base_next      = base_reg;
        rnd_next       = rnd_reg;
        diff_next      = diff_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ready_res_next = ready_res_reg;
        offset_next    = offset_reg;
        ping_next      = ping_reg;
        delay_next     = delay_reg;
        pos_next       = pos_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = op;
                    tgt_next  = target_server_ms;
                    now_next  = local_now_ms;
                    base_next = base_position_ticks;
                    rnd_next  = s_half[49:0];
                    step_next = '0;
                    case (op)
                        comdf_pkg::OP_ADD:
                        begin
                            if (count_reg != CNT_MAX)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                            state_next = ST_SCAN;
                        end
                        comdf_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_QDIFF;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                step_next = step_reg + CNT_W'(1);
                if (step_reg == STEP_END)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_QDIFF:
            begin
                if (op_reg == comdf_pkg::OP_DELAY)
                begin
                    diff_next = tgt_e - rnd_e - now_e;
                end
                else
                begin
                    diff_next = now_e + rnd_e - tgt_e;
                end
                state_next = ST_QMUL;
            end
            ST_QMUL:
            begin
                prod_next  = diff_pos ? ({14'h0000, diff_reg[49:0]} * {50'd0, comdf_pkg::TICKS_PER_MS})
                                      : 64'd0;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    ready_res_next = (count_reg != '0);
                    offset_next    = (count_reg != '0) ? best.offset : 50'sd0;
                    ping_next      = ((count_reg != '0) && !best.delay[49] && (best.delay != '0))
                                     ? best.delay[48:0] : 49'd0;
                    delay_next     = '0;
                    pos_next       = '0;
                    if (op_reg == comdf_pkg::OP_DELAY)
                    begin
                        delay_next = diff_pos ? diff_reg[48:0] : 49'd0;
                    end
                    else if (op_reg == comdf_pkg::OP_POS)
                    begin
                        pos_next = (pos_sum > {2'b00, comdf_pkg::POS_MAX})
                                   ? comdf_pkg::POS_MAX : pos_sum[61:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        tgt_reg       <= tgt_next;
        now_reg       <= now_next;
        base_reg      <= base_next;
        rnd_reg       <= rnd_next;
        diff_reg      <= diff_next;
        prod_reg      <= prod_next;
        ready_res_reg <= ready_res_next;
        offset_reg    <= offset_next;
        ping_reg      <= ping_next;
        delay_reg     <= delay_next;
        pos_reg       <= pos_next;
    end

    assign out_valid         = out_valid_reg;
    assign ready_res         = ready_res_reg;
    assign offset_half_ms    = offset_reg;
    assign ping_half_ms      = ping_reg;
    assign delay_ms          = delay_reg;
    assign position_estimate = pos_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("sample count beyond window");

    a_add_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == comdf_pkg::OP_ADD)) |=> (count_reg != '0) && (state_reg == ST_SCAN))
        else $error("add transaction did not start a scan");

    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && (step_reg == STEP_END)) |=> (state_reg == ST_DONE))
        else $error("scan did not end after window length");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");
`endif

endmodule

// ----- rtl/core/comdf_cell.sv -----
// ----------------------------------------------------------------------------
// comdf_cell
// One window cell: holds a sample, takes its neighbor's sample when enabled.
// ----------------------------------------------------------------------------
module comdf_cell (
    input  logic              clk,
    input  logic              en,
    input  comdf_pkg::sample_t d,
    output comdf_pkg::sample_t q
);

    comdf_pkg::sample_t sample_reg;
    comdf_pkg::sample_t sample_next;

    always_comb
    begin
        sample_next = en ? d : sample_reg;
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    assign q = sample_reg;

endmodule

// ----- rtl/core/comdf_best.sv -----
// ----------------------------------------------------------------------------
// comdf_best
// Running minimum-delay tracker; strict compare keeps the earlier sample on
// a tie. Its register is the chosen sample between scans.
// ----------------------------------------------------------------------------
module comdf_best (
    input  logic                clk,
    input  logic                rst_n,
    input  comdf_pkg::best_ctl_t ctl,
    input  comdf_pkg::sample_t   cand,
    output comdf_pkg::sample_t   best
);

    comdf_pkg::sample_t best_reg;
    comdf_pkg::sample_t best_next;

    always_comb
    begin
        best_next = best_reg;
        if (ctl.clr)
        begin
            best_next = '0;
        end
        else if (ctl.take && (ctl.first || (cand.delay < best_reg.delay)))
        begin
            best_next = cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    assign best = best_reg;

endmodule
